>>> src/gpc_pkg.sv
// Shared types and constants for the glyph pixel combiner.
package gpc_pkg;

   localparam int PIX_W      = 8;
   localparam int COORD_W    = 12;
   localparam int CLIP_W     = 12;
   localparam int GROUP_SIZE = 32;
   localparam int GROUP_BITS = $clog2(GROUP_SIZE);
   localparam int GROUP_MAX  = GROUP_SIZE - 1;
   localparam int PAL_DEPTH  = 256;
   localparam int PAL_AW     = $clog2(PAL_DEPTH);

   // register reset values
   localparam logic [CLIP_W-1:0] CLIP_MAX_X_RST    = CLIP_W'(640);
   localparam logic [CLIP_W-1:0] SCREEN_HEIGHT_RST = CLIP_W'(480);

   // configuration register indexes
   localparam logic CSR_CLIP_MAX_X    = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   // item kinds
   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_PALETTE = 1'b1;

   typedef enum logic [2:0] {
      MODE_PLAIN    = 3'd0,
      MODE_GLOW     = 3'd1,
      MODE_UNGLOW   = 3'd2,
      MODE_RECOLOR  = 3'd3,
      MODE_BRIGHTEN = 3'd4,
      MODE_SOLID    = 3'd5
   } mode_type;

   // payload of the second pipeline stage
   typedef struct packed {
      mode_type                mode;
      logic                    ok;      // opaque and inside clip window
      logic [PIX_W-1:0]        src;
      logic [PIX_W-1:0]        dst;
      logic [PIX_W-1:0]        color;
      logic [PIX_W-1:0]        pal;     // translated source
      logic signed [PIX_W:0]   glow_t;  // (pal & 31) + bright
      logic [PIX_W-1:0]        sum;     // src + bright, wrapped
      logic                    bpos;    // bright > 0
   } stage2_type;

endpackage

>>> src/gpc_palette.sv
// Palette translation table: 256x8 memory with per-entry valid bits, identity at reset.
module gpc_palette (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [gpc_pkg::PAL_AW-1:0]     wr_addr,
   input  logic [gpc_pkg::PIX_W-1:0]      wr_data,
   input  logic                           rd_en,
   input  logic [gpc_pkg::PAL_AW-1:0]     rd_addr,
   output logic [gpc_pkg::PIX_W-1:0]      rd_data
);

   logic [gpc_pkg::PIX_W-1:0]     mem [gpc_pkg::PAL_DEPTH];
   logic [gpc_pkg::PAL_DEPTH-1:0] valid_ff;
   logic [gpc_pkg::PIX_W-1:0]     rdata_ff;
   logic                          rvalid_ff;
   logic [gpc_pkg::PAL_AW-1:0]    raddr_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // valid bits, cleared at reset so unwritten entries read as their index
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
         raddr_ff  <= rd_addr;
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : gpc_pkg::PIX_W'(raddr_ff);

endmodule

>>> src/gpc_blend.sv
// Final mode combine: plain/solid writes, glow/unglow saturation, recolor/brighten group clamp.
module gpc_blend (
   input  gpc_pkg::stage2_type           s2,
   output logic                          we,
   output logic [gpc_pkg::PIX_W-1:0]     pixel
);

   localparam int GB = gpc_pkg::GROUP_BITS;
   localparam int PW = gpc_pkg::PIX_W;

   logic [PW-1:0]  glow_sum;
   logic [GB-1:0]  glow_v;
   logic           glow_go;
   logic [GB-1:0]  unglow_t;
   logic [GB-1:0]  unglow_v;
   logic           crossed;
   logic [GB-1:0]  clamp_low;
   logic [GB-1:0]  recolor_low;
   logic [PW-1:0]  brighten_v;

   always_comb begin
      // glow: add to low bits of destination, saturate at group max
      glow_go  = !s2.glow_t[PW] && (s2.glow_t != '0);
      glow_sum = PW'(s2.dst[GB-1:0]) + s2.glow_t[PW-1:0];
      glow_v   = (glow_sum > PW'(gpc_pkg::GROUP_MAX)) ? GB'(gpc_pkg::GROUP_MAX)
                                                      : glow_sum[GB-1:0];

      // unglow: subtract, floor at zero
      unglow_t = s2.pal[GB-1:0];
      unglow_v = (s2.dst[GB-1:0] >= unglow_t) ? (s2.dst[GB-1:0] - unglow_t) : '0;

      // group change check shared by recolor and brighten
      crossed     = s2.sum[PW-1:GB] != s2.src[PW-1:GB];
      clamp_low   = s2.bpos ? GB'(gpc_pkg::GROUP_MAX) : '0;
      recolor_low = crossed ? clamp_low : s2.sum[GB-1:0];
      brighten_v  = crossed ? {s2.src[PW-1:GB], clamp_low} : s2.sum;

      we    = 1'b0;
      pixel = s2.dst;
      if (s2.ok) begin
         case (s2.mode)
            gpc_pkg::MODE_PLAIN: begin
               we    = 1'b1;
               pixel = s2.pal;
            end
            gpc_pkg::MODE_GLOW: begin
               if (glow_go) begin
                  we    = 1'b1;
                  pixel = {s2.dst[PW-1:GB], glow_v};
               end
            end
            gpc_pkg::MODE_UNGLOW: begin
               if (unglow_t != '0) begin
                  we    = 1'b1;
                  pixel = {s2.dst[PW-1:GB], unglow_v};
               end
            end
            gpc_pkg::MODE_RECOLOR: begin
               we    = 1'b1;
               pixel = {s2.color[PW-GB-1:0], recolor_low};
            end
            gpc_pkg::MODE_BRIGHTEN: begin
               we    = 1'b1;
               pixel = brighten_v;
            end
            gpc_pkg::MODE_SOLID: begin
               we    = 1'b1;
               pixel = s2.color;
            end
            default: begin
               we    = 1'b0;
               pixel = s2.dst;
            end
         endcase
      end
   end

endmodule

>>> src/glyph_pixel_combiner_core.sv
// Top level of the glyph pixel combiner: three-stage pipeline with palette lookup.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser kind; tdata mode..pal_value (80 bits)
//  rsp     | out | rsp_tvalid/rsp_tready | tuser write_enable; tdata new_pixel
//  csr     | in  | csr_we (no wait)      | csr_addr index, csr_wdata 12 bits
//
// One word per cycle sustained while the sink is ready; a pixel word's result goes through
// capture + palette read, translate/add, then combine into the output register.
// Palette words write the table at acceptance and give no result.
// Each stage holds while the one ahead is full and stalled; empty stages still fill.
// Synchronous active-high reset clears valid bits and palette valid flags and loads
// the clip registers with 640 by 480.
module glyph_pixel_combiner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] kind
   input  logic [79:0] req_tdata,   // [2:0] mode, [10:3] src_pixel, [18:11] dst_pixel,
                                    // [30:19] x_pos, [42:31] y_pos, [50:43] bright,
                                    // [58:51] color, [66:59] pal_index, [74:67] pal_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] write_enable
   output logic [7:0]  rsp_tdata,   // [7:0] new_pixel
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [11:0] csr_wdata
);

   localparam int PW = gpc_pkg::PIX_W;
   localparam int CW = gpc_pkg::COORD_W;

   // field unpack
   logic [2:0]    f_mode;
   logic [PW-1:0] f_src, f_dst, f_bright, f_color, f_pidx, f_pval;
   logic [CW-1:0] f_x, f_y;

   assign f_mode   = req_tdata[2:0];
   assign f_src    = req_tdata[10:3];
   assign f_dst    = req_tdata[18:11];
   assign f_x      = req_tdata[30:19];
   assign f_y      = req_tdata[42:31];
   assign f_bright = req_tdata[50:43];
   assign f_color  = req_tdata[58:51];
   assign f_pidx   = req_tdata[66:59];
   assign f_pval   = req_tdata[74:67];

   // configuration registers
   logic [gpc_pkg::CLIP_W-1:0] clip_max_x_ff, screen_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_max_x_ff    <= gpc_pkg::CLIP_MAX_X_RST;
         screen_height_ff <= gpc_pkg::SCREEN_HEIGHT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            gpc_pkg::CSR_CLIP_MAX_X:    clip_max_x_ff    <= csr_wdata;
            gpc_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake chain
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;
   logic req_fire, pix_fire, pal_fire;

   assign rdy3     = !v3_ff || rsp_tready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign req_fire = req_tvalid && rdy1;
   assign pix_fire = req_fire && (req_tuser == gpc_pkg::KIND_PIXEL);
   assign pal_fire = req_fire && (req_tuser == gpc_pkg::KIND_PALETTE);

   always_comb begin
      v1_in = rdy1 ? pix_fire : v1_ff;
      v2_in = rdy2 ? v1_ff    : v2_ff;
      v3_in = rdy3 ? v2_ff    : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: capture, clip test, palette read
   logic          ok_in;
   logic          x_ok, y_ok;
   logic [2:0]    s1_mode_ff;
   logic [PW-1:0] s1_src_ff, s1_dst_ff, s1_bright_ff, s1_color_ff;
   logic          s1_ok_ff;
   logic [PW-1:0] pal_rd;

   always_comb begin
      x_ok  = !f_x[CW-1] && (f_x != '0) && ({1'b0, f_x[CW-2:0]} < clip_max_x_ff);
      y_ok  = !f_y[CW-1] && (f_y != '0) && ({1'b0, f_y[CW-2:0]} < screen_height_ff);
      ok_in = (f_src != '0) && x_ok && y_ok;
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         s1_mode_ff   <= f_mode;
         s1_src_ff    <= f_src;
         s1_dst_ff    <= f_dst;
         s1_bright_ff <= f_bright;
         s1_color_ff  <= f_color;
         s1_ok_ff     <= ok_in;
      end
   end

   gpc_palette u_palette (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pal_fire),
      .wr_addr (f_pidx),
      .wr_data (f_pval),
      .rd_en   (pix_fire),
      .rd_addr (f_src),
      .rd_data (pal_rd)
   );

   // stage 2: translate and first adds
   gpc_pkg::stage2_type s2_in, s2_ff;

   always_comb begin
      s2_in.mode   = gpc_pkg::mode_type'(s1_mode_ff);
      s2_in.ok     = s1_ok_ff;
      s2_in.src    = s1_src_ff;
      s2_in.dst    = s1_dst_ff;
      s2_in.color  = s1_color_ff;
      s2_in.pal    = pal_rd;
      s2_in.glow_t = $signed({4'b0, pal_rd[gpc_pkg::GROUP_BITS-1:0]})
                   + $signed({s1_bright_ff[PW-1], s1_bright_ff});
      s2_in.sum    = s1_src_ff + s1_bright_ff;
      s2_in.bpos   = !s1_bright_ff[PW-1] && (s1_bright_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: combine into output register
   logic          we_in;
   logic [PW-1:0] pixel_in;
   logic          we_ff;
   logic [PW-1:0] pixel_ff;

   gpc_blend u_blend (
      .s2    (s2_ff),
      .we    (we_in),
      .pixel (pixel_in)
   );

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         we_ff    <= we_in;
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tuser  = we_ff;
   assign rsp_tdata  = pixel_ff;

endmodule

>>> src/gpc_checker.sv
// Port-level checker for the glyph pixel combiner, bound to the top level.
module gpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic [79:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tuser,
   input logic [7:0]  rsp_tdata
);

   logic pix_fire;
   assign pix_fire = req_tvalid && req_tready && (req_tuser == gpc_pkg::KIND_PIXEL);

   // a held result word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // with the sink ready while it moves through the stages, a pixel word reaches the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      pix_fire ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("pixel word did not reach the output");

   // transparent source: no write and destination passed through
   a_transparent: assert property (@(posedge clock) disable iff (reset)
      pix_fire && (req_tdata[10:3] == 8'd0) ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid && !rsp_tuser && (rsp_tdata == $past(req_tdata[18:11], 3)))
      else $error("transparent pixel was written");

   // left of or on the left clip edge: no write
   a_clip_left: assert property (@(posedge clock) disable iff (reset)
      pix_fire && (req_tdata[30] || (req_tdata[30:19] == 12'd0))
      ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid && !rsp_tuser)
      else $error("clipped pixel was written");

endmodule

bind glyph_pixel_combiner_core gpc_checker u_gpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
